FILE: rtl/swept_circle_collision_test_core_macros.svh
// assertion macros for the swept circle collision test core
// used by modules that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef SWEPT_CIRCLE_COLLISION_TEST_CORE_MACROS_SVH
`define SWEPT_CIRCLE_COLLISION_TEST_CORE_MACROS_SVH

// property must hold at every clock edge outside reset
`define SCCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be true outside reset
`define SCCT_NEVER(lbl, cond, msg) \
  `SCCT_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/scct_pkg.sv
// shared types and widths for the swept circle collision test core
// no dependencies
package scct_pkg;

  localparam int unsigned NbW  = 50;  // magnitude of p.v
  localparam int unsigned AaW  = 50;  // |v|^2 and |p|^2 - g^2
  localparam int unsigned AatW = 66;  // |v|^2 * time window
  localparam int unsigned ExW  = 42;  // magnitude of 256*p + t*v per axis
  localparam int unsigned GgW  = 34;  // squared radius sum

  // word handed from the front stages to the back stages
  typedef struct packed {
    logic             overlap;
    logic             aa_zero;
    logic             pv_nonneg;
    logic [NbW-1:0]   nb;
    logic [AaW-1:0]   aa;
    logic [AaW-1:0]   cc;
    logic [AatW-1:0]  aat;
    logic [ExW-1:0]   exm;
    logic [ExW-1:0]   eym;
    logic [GgW-1:0]   gg;
  } scct_mid_t;

endpackage

FILE: rtl/scct_front.sv
// front stages: differences, products, sums and magnitudes (four stages)
// depends on scct_pkg
module scct_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic [15:0]            radius_a_i,
  input  logic signed [23:0]     pos_a_x_i,
  input  logic signed [23:0]     pos_a_y_i,
  input  logic signed [23:0]     vel_a_x_i,
  input  logic signed [23:0]     vel_a_y_i,
  input  logic [15:0]            radius_b_i,
  input  logic signed [23:0]     pos_b_x_i,
  input  logic signed [23:0]     pos_b_y_i,
  input  logic signed [23:0]     vel_b_x_i,
  input  logic signed [23:0]     vel_b_y_i,
  input  logic [15:0]            time_window_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output scct_pkg::scct_mid_t    mid_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage enables: a stage moves when empty or when the next one moves
  assign en4 = !v4_q || !stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: relative position, velocity and radius sum
  logic signed [24:0] px1_d, py1_d, vx1_d, vy1_d;
  logic signed [24:0] px1_q, py1_q, vx1_q, vy1_q;
  logic [16:0]        g1_d, g1_q;
  logic [15:0]        t1_q;

  assign px1_d = 25'(pos_a_x_i) - 25'(pos_b_x_i);
  assign py1_d = 25'(pos_a_y_i) - 25'(pos_b_y_i);
  assign vx1_d = 25'(vel_a_x_i) - 25'(vel_b_x_i);
  assign vy1_d = 25'(vel_a_y_i) - 25'(vel_b_y_i);
  assign g1_d  = 17'(radius_a_i) + 17'(radius_b_i);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      px1_q <= px1_d;
      py1_q <= py1_d;
      vx1_q <= vx1_d;
      vy1_q <= vy1_d;
      g1_q  <= g1_d;
      t1_q  <= time_window_i;
    end
  end

  // stage 2: squares, dot product terms, window products
  logic signed [49:0] pxx_f, pyy_f, vxx_f, vyy_f, pxv_d, pyv_d;
  logic signed [41:0] tvx_d, tvy_d;
  logic [33:0]        gg2_d;
  logic [48:0]        pxx2_q, pyy2_q, vxx2_q, vyy2_q;
  logic signed [49:0] pxv2_q, pyv2_q;
  logic signed [41:0] tvx2_q, tvy2_q;
  logic [33:0]        gg2_q;
  logic signed [24:0] px2_q, py2_q;
  logic [15:0]        t2_q;

  assign pxx_f = px1_q * px1_q;
  assign pyy_f = py1_q * py1_q;
  assign vxx_f = vx1_q * vx1_q;
  assign vyy_f = vy1_q * vy1_q;
  assign pxv_d = px1_q * vx1_q;
  assign pyv_d = py1_q * vy1_q;
  assign tvx_d = $signed({1'b0, t1_q}) * vx1_q;
  assign tvy_d = $signed({1'b0, t1_q}) * vy1_q;
  assign gg2_d = 34'(g1_q) * 34'(g1_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pxx2_q <= pxx_f[48:0];
      pyy2_q <= pyy_f[48:0];
      vxx2_q <= vxx_f[48:0];
      vyy2_q <= vyy_f[48:0];
      pxv2_q <= pxv_d;
      pyv2_q <= pyv_d;
      tvx2_q <= tvx_d;
      tvy2_q <= tvy_d;
      gg2_q  <= gg2_d;
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      t2_q   <= t1_q;
    end
  end

  // stage 3: sums of squares, dot product, position at window end
  logic [49:0]        pp3_d, aa3_d, pp3_q, aa3_q;
  logic signed [50:0] pv3_d, pv3_q;
  logic signed [41:0] ex3_d, ey3_d, ex3_q, ey3_q;
  logic [33:0]        gg3_q;
  logic [15:0]        t3_q;

  assign pp3_d = 50'(pxx2_q) + 50'(pyy2_q);
  assign aa3_d = 50'(vxx2_q) + 50'(vyy2_q);
  assign pv3_d = 51'(pxv2_q) + 51'(pyv2_q);
  assign ex3_d = 42'($signed({px2_q, 8'h00})) + tvx2_q;
  assign ey3_d = 42'($signed({py2_q, 8'h00})) + tvy2_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pp3_q <= pp3_d;
      aa3_q <= aa3_d;
      pv3_q <= pv3_d;
      ex3_q <= ex3_d;
      ey3_q <= ey3_d;
      gg3_q <= gg2_q;
      t3_q  <= t2_q;
    end
  end

  // stage 4: flags, magnitudes, distance margin, window scaled speed
  scct_pkg::scct_mid_t mid_d, mid_q;
  logic signed [50:0] pv_neg;
  logic signed [41:0] ex_neg, ey_neg;

  assign pv_neg = -pv3_q;
  assign ex_neg = -ex3_q;
  assign ey_neg = -ey3_q;

  always_comb begin
    mid_d.overlap   = (pp3_q <= 50'(gg3_q));
    mid_d.aa_zero   = (aa3_q == '0);
    mid_d.pv_nonneg = !pv3_q[50];
    mid_d.nb        = pv3_q[50] ? pv_neg[49:0] : pv3_q[49:0];
    mid_d.aa        = aa3_q;
    mid_d.cc        = pp3_q - 50'(gg3_q);
    mid_d.aat       = 66'(aa3_q) * 66'(t3_q);
    mid_d.exm       = ex3_q[41] ? ex_neg : ex3_q;
    mid_d.eym       = ey3_q[41] ? ey_neg : ey3_q;
    mid_d.gg        = gg3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en4) mid_q <= mid_d;
  end

  assign valid_o = v4_q;
  assign mid_o   = mid_q;

endmodule

FILE: rtl/scct_back.sv
// back stages: split wide products, recombine, final decision (three stages)
// depends on scct_pkg and the assertion macro header
`include "swept_circle_collision_test_core_macros.svh"

module scct_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  scct_pkg::scct_mid_t  mid_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic                 collides_o
);

  logic v5_q, v6_q, v7_q;
  logic en5, en6, en7;

  // stage enables
  assign en7 = !v7_q || !stall_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign stall_o = !en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // stage 5: partial products of the three wide squares and products
  logic [24:0] nh, nl, ah, al, ch, cl;
  logic [20:0] exh, exl, eyh, eyl;
  logic        flag5_d;
  logic [49:0] nhh5_q, nhl5_q, nll5_q;
  logic [49:0] ahh5_q, ahl5_q, alh5_q, all5_q;
  logic [41:0] xhh5_q, xhl5_q, xll5_q, yhh5_q, yhl5_q, yll5_q;
  logic        early5_q, flag5_q, overlap5_q;
  logic [49:0] rhs5_q;

  assign nh  = mid_i.nb[49:25];
  assign nl  = mid_i.nb[24:0];
  assign ah  = mid_i.aa[49:25];
  assign al  = mid_i.aa[24:0];
  assign ch  = mid_i.cc[49:25];
  assign cl  = mid_i.cc[24:0];
  assign exh = mid_i.exm[41:21];
  assign exl = mid_i.exm[20:0];
  assign eyh = mid_i.eym[41:21];
  assign eyl = mid_i.eym[20:0];
  // a contact can only follow if closing with nonzero speed
  assign flag5_d = !mid_i.aa_zero && !mid_i.pv_nonneg;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      nhh5_q     <= 50'(nh) * 50'(nh);
      nhl5_q     <= 50'(nh) * 50'(nl);
      nll5_q     <= 50'(nl) * 50'(nl);
      ahh5_q     <= 50'(ah) * 50'(ch);
      ahl5_q     <= 50'(ah) * 50'(cl);
      alh5_q     <= 50'(al) * 50'(ch);
      all5_q     <= 50'(al) * 50'(cl);
      xhh5_q     <= 42'(exh) * 42'(exh);
      xhl5_q     <= 42'(exh) * 42'(exl);
      xll5_q     <= 42'(exl) * 42'(exl);
      yhh5_q     <= 42'(eyh) * 42'(eyh);
      yhl5_q     <= 42'(eyh) * 42'(eyl);
      yll5_q     <= 42'(eyl) * 42'(eyl);
      early5_q   <= (66'({mid_i.nb, 8'h00}) < mid_i.aat);
      flag5_q    <= flag5_d;
      overlap5_q <= mid_i.overlap;
      rhs5_q     <= {mid_i.gg, 16'h0000};
    end
  end

  // stage 6: recombine partial products
  logic [99:0] nb2_q, acc_q;
  logic [83:0] e2_q;
  logic        early6_q, flag6_q, overlap6_q;
  logic [49:0] rhs6_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      nb2_q <= (100'(nhh5_q) << 50) + (100'(nhl5_q) << 26) + 100'(nll5_q);
      acc_q <= (100'(ahh5_q) << 50) + ((100'(ahl5_q) + 100'(alh5_q)) << 25)
             + 100'(all5_q);
      e2_q  <= (84'(xhh5_q) << 42) + (84'(xhl5_q) << 22) + 84'(xll5_q)
             + (84'(yhh5_q) << 42) + (84'(yhl5_q) << 22) + 84'(yll5_q);
      early6_q   <= early5_q;
      flag6_q    <= flag5_q;
      overlap6_q <= overlap5_q;
      rhs6_q     <= rhs5_q;
    end
  end

  // stage 7: real root test and window test
  logic collides_d, collides_q;

  assign collides_d = overlap6_q
                   || (flag6_q && !(nb2_q < acc_q)
                       && (early6_q || (e2_q < 84'(rhs6_q))));

  always_ff @(posedge clk_i) begin
    if (en7) collides_q <= collides_d;
  end

  assign valid_o    = v7_q;
  assign collides_o = collides_q;

  // checks
  `SCCT_ASSERT(a_advance, v6_q && en7 |=> v7_q, "word lost between last two stages")
  `SCCT_ASSERT(a_overlap, v6_q && overlap6_q && en7 |=> collides_q, "overlap not flagged")
  `SCCT_NEVER(a_empty_stall, !v5_q && stall_o, "stall raised with empty entry stage")

endmodule

FILE: rtl/swept_circle_collision_test_core.sv
// result path: an accepted word passes the front stages, then the back stages, to collides_o
// throughput: one item per cycle while stall_i is low; every stage is a registered slice of the math
// the widest paths are the 25x25 and 50x16 products or a 100-bit recombination add
// stall propagates stage by stage so empty stages keep filling
// reset: rst_ni asynchronous active low clears all stage valid bits
module swept_circle_collision_test_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [15:0]        radius_a_i,
  input  logic signed [23:0] pos_a_x_i,
  input  logic signed [23:0] pos_a_y_i,
  input  logic signed [23:0] vel_a_x_i,
  input  logic signed [23:0] vel_a_y_i,
  input  logic [15:0]        radius_b_i,
  input  logic signed [23:0] pos_b_x_i,
  input  logic signed [23:0] pos_b_y_i,
  input  logic signed [23:0] vel_b_x_i,
  input  logic signed [23:0] vel_b_y_i,
  input  logic [15:0]        time_window_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               collides_o
);

  scct_pkg::scct_mid_t mid;
  logic                mid_valid;
  logic                mid_stall;

  // geometry front end
  scct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .radius_a_i    (radius_a_i),
    .pos_a_x_i     (pos_a_x_i),
    .pos_a_y_i     (pos_a_y_i),
    .vel_a_x_i     (vel_a_x_i),
    .vel_a_y_i     (vel_a_y_i),
    .radius_b_i    (radius_b_i),
    .pos_b_x_i     (pos_b_x_i),
    .pos_b_y_i     (pos_b_y_i),
    .vel_b_x_i     (vel_b_x_i),
    .vel_b_y_i     (vel_b_y_i),
    .time_window_i (time_window_i),
    .valid_o       (mid_valid),
    .stall_i       (mid_stall),
    .mid_o         (mid)
  );

  // wide products and decision
  scct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mid_valid),
    .stall_o    (mid_stall),
    .mid_i      (mid),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .collides_o (collides_o)
  );

endmodule
